[hw/rtl/wrv_pkg.sv]
// package for the windowed realized variance block: types, constants, codes
package wrv_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PRICE_BITS = 24;
  localparam int IDX_BITS   = $clog2(RING_DEPTH);
  localparam int CNT_BITS   = $clog2(RING_DEPTH + 1);
  localparam int TIME_BITS  = 48;
  localparam int SUM_BITS   = 56;
  localparam int VAR_BITS   = 63;
  localparam int SIG_BITS   = 32;
  localparam int ENTRY_BITS = 3 * TIME_BITS;

  localparam logic [31:0] SAMPLE_RESET = 32'd1000;
  localparam logic [47:0] WINDOW_RESET = 48'd60000000;
  localparam logic [19:0] SCALE        = 20'd1000000;

  localparam logic       CMD_OBSERVE = 1'b0;
  localparam logic       CMD_CLEAR   = 1'b1;
  localparam logic [0:0] REG_SAMPLE  = 1'b0;
  localparam logic [0:0] REG_WINDOW  = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [TIME_BITS-1:0]  time_us;
    logic [PRICE_BITS-1:0] price;
  } wrv_in_t;

  typedef struct packed {
    logic                 sample_taken;
    logic                 oldest_dropped;
    logic [8:0]           entries_in_window;
    logic [VAR_BITS-1:0]  variance_per_sec;
    logic [SIG_BITS-1:0]  sigma;
  } wrv_out_t;

  // request and answer between the sequencer and the math unit
  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] num;
    logic [SUM_BITS-1:0] den;
  } wrv_math_req_t;

  typedef struct packed {
    logic                done;
    logic [VAR_BITS-1:0] quot;
    logic [SIG_BITS-1:0] root;
  } wrv_math_rsp_t;

endpackage

[hw/rtl/wrv_ram.sv]
// generic single port ram with registered read
module wrv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/wrv_math.sv]
// shared iterative unit: scaled division then square root, one bit a cycle
module wrv_math import wrv_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  wrv_math_req_t req,
  output wrv_math_rsp_t rsp
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_MUL  = 5'b00010,
    M_DIV  = 5'b00100,
    M_SQRT = 5'b01000,
    M_DONE = 5'b10000
  } mstate_t;

  mstate_t             state;
  logic [6:0]          step;
  logic [75:0]         dividend;
  logic [SUM_BITS:0]   rem;
  logic [SUM_BITS-1:0] den;
  logic [VAR_BITS-1:0] quot;
  logic                sat;
  logic [63:0]         sv;
  logic [63:0]         sres;
  logic [63:0]         sbit;

  logic [SUM_BITS:0]   rem_sh;
  logic                take;
  logic [63:0]         trial;

  // 76-bit dividend; bit positions 75..63 give saturation
  assign rem_sh = {rem[SUM_BITS-1:0], dividend[75]};
  assign take   = rem_sh >= {1'b0, den};
  assign trial  = sres + sbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: if (req.start) begin
          dividend <= {20'd0, req.num};
          den      <= req.den;
          state    <= (req.den == '0) ? M_DONE : M_MUL;
          quot     <= '0;
          sres     <= '0;
          sat      <= 1'b0;
        end
        M_MUL: begin
          dividend <= dividend[55:0] * SCALE;
          rem      <= '0;
          step     <= 7'd75;
          state    <= M_DIV;
        end
        M_DIV: begin
          dividend <= {dividend[74:0], 1'b0};
          rem      <= take ? rem_sh - {1'b0, den} : rem_sh;
          if (step == 7'd0) begin
            state <= M_SQRT;
            sbit  <= 64'd1 << 62;
            sres  <= '0;
            if (sat) begin
              quot <= {VAR_BITS{1'b1}};
              sv   <= {1'b0, {VAR_BITS{1'b1}}};
            end else begin
              quot <= {quot[VAR_BITS-2:0], take};
              sv   <= {1'b0, quot[VAR_BITS-2:0], take};
            end
          end else begin
            step <= step - 7'd1;
            if (take && step >= 7'd63) begin
              sat <= 1'b1;
            end
            if (step < 7'd63) begin
              quot <= {quot[VAR_BITS-2:0], take};
            end
          end
        end
        M_SQRT: begin
          if (sv >= trial) begin
            sv   <= sv - trial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            state <= M_DONE;
          end
        end
        M_DONE: state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = (state == M_DONE);
  assign rsp.quot = (den == '0) ? '0 : quot;
  assign rsp.root = (den == '0) ? '0 : sres[SIG_BITS-1:0];

endmodule

[hw/rtl/windowed_realized_variance_top.sv]
// top level of the windowed realized variance block: sequencer, ring, result register
//
//   channel | direction | handshake    | payload
//   in      | input     | valid, stall | wrv_in_t
//   out     | output    | valid, stall | wrv_out_t
//   cfg     | input     | valid, ready | index, data
//
// a taken sample goes through the due check, a drop of the oldest entry on a full ring,
// the store, a read, wait and check repeated per entry evicted by age, then 76 division
// and 32 square root steps in the math unit; a clear or an empty window skips the math
// reset is synchronous and clears control and the ring pointers; ram contents stay
// in_stall is high while an item is at work or its result is still waiting
module windowed_realized_variance_top import wrv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  wrv_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output wrv_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DROPR = 8'b00000010,
    S_DROPW = 8'b00000100,
    S_STORE = 8'b00001000,
    S_EVR   = 8'b00010000,
    S_EVW   = 8'b00100000,
    S_EVC   = 8'b01000000,
    S_MATH  = 8'b10000000
  } state_t;

  state_t                state;
  logic [31:0]           sample_interval;
  logic [47:0]           window_length;
  logic [IDX_BITS-1:0]   ring_head;
  logic [CNT_BITS-1:0]   ring_count;
  logic [SUM_BITS-1:0]   square_total;
  logic [SUM_BITS-1:0]   elapsed_total;
  logic [47:0]           last_time;
  logic [PRICE_BITS-1:0] last_price;
  logic                  have_reference;
  wrv_in_t               item;
  logic                  taken;
  logic                  dropped;
  logic                  math_busy;

  logic                  we;
  logic [IDX_BITS-1:0]   addr;
  logic [ENTRY_BITS-1:0] wdata;
  logic [ENTRY_BITS-1:0] rdata;
  wrv_math_req_t         mreq;
  wrv_math_rsp_t         mrsp;

  logic [47:0]           dt;
  logic [PRICE_BITS-1:0] dprice;
  logic [47:0]           sq;
  logic [47:0]           e_time, e_sq, e_dt;
  logic                  due;

  assign dt     = item.time_us - last_time;
  assign dprice = (item.price >= last_price) ? item.price - last_price
                                             : last_price - item.price;
  assign sq     = 48'(dprice * dprice);
  assign due    = (item.time_us >= last_time) && (dt >= {16'd0, sample_interval});
  assign {e_time, e_sq, e_dt} = rdata;

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;

  always_comb begin
    we    = 1'b0;
    addr  = ring_head;
    wdata = {item.time_us, sq, dt};
    if (state == S_STORE) begin
      we   = 1'b1;
      addr = IDX_BITS'(ring_head + ring_count[IDX_BITS-1:0]);
    end
  end

  assign mreq.start = (state == S_MATH) && !math_busy;
  assign mreq.num   = square_total;
  assign mreq.den   = (ring_count == '0) ? '0 : elapsed_total;

  wrv_ram #(.WIDTH(ENTRY_BITS), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  wrv_math u_math (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= SAMPLE_RESET;
      window_length   <= WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE: sample_interval <= cfg_data[31:0];
        REG_WINDOW: window_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ring_head      <= '0;
      ring_count     <= '0;
      square_total   <= '0;
      elapsed_total  <= '0;
      last_time      <= '0;
      last_price     <= '0;
      have_reference <= 1'b0;
      out_valid      <= 1'b0;
      math_busy      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          item      <= in_data;
          taken     <= 1'b0;
          dropped   <= 1'b0;
          math_busy <= 1'b0;
          state     <= S_MATH;
          if (in_data.command == CMD_CLEAR) begin
            ring_head      <= '0;
            ring_count     <= '0;
            square_total   <= '0;
            elapsed_total  <= '0;
            last_time      <= '0;
            last_price     <= '0;
            have_reference <= 1'b0;
          end else if (!have_reference) begin
            last_time      <= in_data.time_us;
            last_price     <= in_data.price;
            have_reference <= 1'b1;
          end else begin
            state <= S_DROPR;
          end
        end
        S_DROPR: begin
          if (!due) begin
            state <= S_MATH;
          end else if (ring_count >= CNT_BITS'(RING_DEPTH)) begin
            state <= S_DROPW;
          end else begin
            state <= S_STORE;
          end
        end
        S_DROPW: begin
          // full ring: the oldest entry leaves the sums
          square_total  <= square_total - SUM_BITS'(e_sq);
          elapsed_total <= elapsed_total - SUM_BITS'(e_dt);
          ring_head     <= ring_head + 1'b1;
          ring_count    <= ring_count - 1'b1;
          dropped       <= 1'b1;
          state         <= S_STORE;
        end
        S_STORE: begin
          ring_count    <= ring_count + 1'b1;
          square_total  <= square_total + SUM_BITS'(sq);
          elapsed_total <= elapsed_total + SUM_BITS'(dt);
          last_time     <= item.time_us;
          last_price    <= item.price;
          taken         <= 1'b1;
          state         <= S_EVR;
        end
        S_EVR: state <= S_EVW;
        S_EVW: state <= S_EVC;
        S_EVC: begin
          if (ring_count != '0 && (item.time_us - e_time) > window_length) begin
            square_total  <= square_total - SUM_BITS'(e_sq);
            elapsed_total <= elapsed_total - SUM_BITS'(e_dt);
            ring_head     <= ring_head + 1'b1;
            ring_count    <= ring_count - 1'b1;
            state         <= S_EVR;
          end else begin
            state <= S_MATH;
          end
        end
        S_MATH: begin
          math_busy <= 1'b1;
          if (math_busy && mrsp.done) begin
            out_valid                  <= 1'b1;
            out_data.sample_taken      <= taken;
            out_data.oldest_dropped    <= dropped;
            out_data.entries_in_window <= 9'(ring_count);
            out_data.variance_per_sec  <= mrsp.quot;
            out_data.sigma             <= mrsp.root;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/wrv_checker.sv]
// port checker for the windowed realized variance block, bound to the top level
module wrv_checker import wrv_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input wrv_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is at work");

  a_result_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item taken while a result waits");

  a_sigma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.variance_per_sec == '0 |-> out_data.sigma == '0)
    else $error("nonzero sigma for zero variance");

endmodule

bind windowed_realized_variance_top wrv_checker u_wrv_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[tb/testbench.sv]
// testbench for the windowed realized variance block: scoreboard, drivers, run control
`timescale 1ns / 1ps

module testbench;
  import wrv_pkg::*;

  class variance_scoreboard;
    logic [31:0] interval;
    logic [47:0] window;
    logic [47:0] e_time [RING_DEPTH];
    logic [47:0] e_sq [RING_DEPTH];
    logic [47:0] e_dt [RING_DEPTH];
    int unsigned head, count;
    logic [63:0] sq_sum, dt_sum, ref_time, ref_price;
    bit have_ref;
    wrv_out_t pending[$];
    int errors;

    function new();
      interval = SAMPLE_RESET;
      window = WINDOW_RESET;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      head = 0;
      count = 0;
      sq_sum = 0;
      dt_sum = 0;
      ref_time = 0;
      ref_price = 0;
      have_ref = 0;
    endfunction

    function void pop_oldest();
      sq_sum -= e_sq[head];
      dt_sum -= e_dt[head];
      head = (head + 1) % RING_DEPTH;
      count--;
    endfunction

    function logic [62:0] scaled(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = ({64'd0, num} * 128'd1000000) / {64'd0, den};
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) return '1;
      return q[62:0];
    endfunction

    function logic [31:0] root(logic [62:0] v);
      logic [63:0] r;
      logic [63:0] lo, hi, mid;
      lo = 0;
      hi = 64'd4294967296;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid <= {1'b0, v}) lo = mid;
        else hi = mid;
      end
      r = lo;
      return r[31:0];
    endfunction

    function void note_item(wrv_in_t it);
      wrv_out_t res;
      logic [63:0] now, p, d, slot;
      now = {16'd0, it.time_us};
      p = {40'd0, it.price};
      res = '0;
      if (it.command == CMD_CLEAR) begin
        wipe();
      end else if (!have_ref) begin
        ref_time = now;
        ref_price = p;
        have_ref = 1;
      end else if (now >= ref_time && now - ref_time >= interval) begin
        d = (p >= ref_price) ? p - ref_price : ref_price - p;
        if (count >= RING_DEPTH) begin
          pop_oldest();
          res.oldest_dropped = 1'b1;
        end
        slot = (head + count) % RING_DEPTH;
        e_time[slot] = now[47:0];
        e_sq[slot] = 48'(d * d);
        e_dt[slot] = 48'(now - ref_time);
        count++;
        sq_sum += d * d;
        dt_sum += now - ref_time;
        ref_time = now;
        ref_price = p;
        res.sample_taken = 1'b1;
        while (count > 0 && now - e_time[head] > window) pop_oldest();
      end
      res.entries_in_window = 9'(count);
      if (count > 0 && dt_sum > 0) res.variance_per_sec = scaled(sq_sum, dt_sum);
      res.sigma = root(res.variance_per_sec);
      pending = {pending, res};
    endfunction

    function void check_result(wrv_out_t got);
      wrv_out_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got.sample_taken !== exp.sample_taken) begin
        $error("sample_taken exp %0d got %0d", exp.sample_taken, got.sample_taken);
        errors++;
      end
      if (got.oldest_dropped !== exp.oldest_dropped) begin
        $error("oldest_dropped exp %0d got %0d", exp.oldest_dropped, got.oldest_dropped);
        errors++;
      end
      if (got.entries_in_window !== exp.entries_in_window) begin
        $error("entries_in_window exp %0d got %0d", exp.entries_in_window,
               got.entries_in_window);
        errors++;
      end
      if (got.variance_per_sec !== exp.variance_per_sec) begin
        $error("variance_per_sec exp %0d got %0d", exp.variance_per_sec,
               got.variance_per_sec);
        errors++;
      end
      if (got.sigma !== exp.sigma) begin
        $error("sigma exp %0d got %0d", exp.sigma, got.sigma);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  wrv_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  wrv_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = REG_SAMPLE;
  logic [47:0] cfg_data = '0;

  variance_scoreboard board = new();
  bit calm = 0;
  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic [47:0] clock_us = 0;
  logic [23:0] price_now = 24'h10000;

  windowed_realized_variance_top dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall, results checked at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end
  always @(negedge clk) begin
    out_stall <= rst ? 1'b1 : (!calm && $urandom_range(99) < 37);
  end

  task automatic send_item(wrv_in_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 37) @(negedge clk);
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SAMPLE) board.interval = val[31:0];
    else board.window = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic observe(logic [47:0] t, logic [23:0] p);
    wrv_in_t it;
    it.command = CMD_OBSERVE;
    it.time_us = t;
    it.price = p;
    send_item(it);
  endtask

  task automatic clear_all();
    wrv_in_t it;
    it.command = CMD_CLEAR;
    it.time_us = 48'($urandom());
    it.price = 24'($urandom());
    send_item(it);
    clock_us = 0;
  endtask

  // random walk in time and price; mostly well-formed, some noise
  task automatic random_phase(int n, int unsigned max_step, int unsigned max_move);
    wrv_in_t it;
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 2) begin
        clear_all();
      end else if (r < 8) begin
        it.command = CMD_OBSERVE;
        it.time_us = 48'({$urandom(), $urandom()});
        it.price = 24'($urandom());
        send_item(it);
        clock_us = it.time_us;
      end else begin
        clock_us = clock_us + 48'($urandom_range(max_step));
        if (r < 12) price_now = 24'($urandom());
        else price_now = 24'(price_now + $urandom_range(2 * max_move) - max_move);
        observe(r < 14 ? 48'(clock_us - $urandom_range(50)) : clock_us, price_now);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset settings, extremes, clear, too early, backwards
    observe(48'd0, 24'd0);
    observe(48'd999, 24'hFFFFFF);
    observe(48'd1000, 24'hFFFFFF);
    observe(48'd2000, 24'd0);
    observe(48'd1500, 24'd7);
    observe(48'hFFFF_FFFF_FFFF, 24'hFFFFFF);
    clear_all();
    observe(48'hFFFF_FFFF_FFF0, 24'h123456);
    observe(48'hFFFF_FFFF_FFFF, 24'h654321);
    clear_all();
    drain();
    write_reg(REG_SAMPLE, 48'd0);
    write_reg(REG_WINDOW, 48'hFFFF_FFFF_FFFF);
    observe(48'd5, 24'd100);
    observe(48'd5, 24'd200);
    observe(48'd5, 24'hFFFFFF);
    observe(48'd6, 24'd0);
    observe(48'd6, 24'hFFFFFF);
    clear_all();
    drain();

    // random runs with the widest window, so no eviction by age
    write_reg(REG_SAMPLE, 48'd1);
    calm = 1;
    random_phase(300, 3, 40);
    calm = 0;
    random_phase(200, 4, 4000);
    drain();

    // short window, eviction by age
    write_reg(REG_WINDOW, 48'd100);
    write_reg(REG_SAMPLE, 48'd10);
    clear_all();
    random_phase(250, 40, 300);
    drain();

    write_reg(REG_WINDOW, 48'd0);
    write_reg(REG_SAMPLE, 48'hFFFF_FFFF);
    clear_all();
    random_phase(40, 32'h7FFF_FFFF, 1000);
    drain();

    write_reg(REG_SAMPLE, 48'd1000);
    write_reg(REG_WINDOW, 48'd60000000);
    clear_all();
    random_phase(450, 3000, 100000);

    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
